[src/hdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_pkg
// shared constants, types and tables for the heading drift corrector
// ----------------------------------------------------------------------------
package hdc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_BITS  = 7;
  localparam int TAB_FRAC         = 24;
  localparam int TAB_LEN          = 24;
  localparam int STEP_W           = 5;

  localparam logic [1:0] REG_NOISE    = 2'd0;
  localparam logic [1:0] REG_MAXSTEP  = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_GAIN     = 2'd3;

  typedef struct packed {
    logic load;
    logic cordic_step;
    logic finish_compass;
    logic form_headings;
    logic div_start_wheel;
    logic div_start_gyro;
    logic div_step;
    logic apply_wheel;
    logic apply_gyro;
  } hdc_cmd_t;

  typedef struct packed {
    logic div_needed;
  } hdc_status_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd754974720;
        5'd1:  r = 32'd445687602;
        5'd2:  r = 32'd235489088;
        5'd3:  r = 32'd119537938;
        5'd4:  r = 32'd60000934;
        5'd5:  r = 32'd30029717;
        5'd6:  r = 32'd15018523;
        5'd7:  r = 32'd7509720;
        5'd8:  r = 32'd3754917;
        5'd9:  r = 32'd1877466;
        5'd10: r = 32'd938734;
        5'd11: r = 32'd469367;
        5'd12: r = 32'd234684;
        5'd13: r = 32'd117342;
        5'd14: r = 32'd58671;
        5'd15: r = 32'd29335;
        5'd16: r = 32'd14668;
        5'd17: r = 32'd7334;
        5'd18: r = 32'd3667;
        5'd19: r = 32'd1833;
        5'd20: r = 32'd917;
        5'd21: r = 32'd458;
        5'd22: r = 32'd229;
        5'd23: r = 32'd115;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

[src/hdc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_ctrl
// sequencer: cordic, heading forming, two serial divides, offset update
// ----------------------------------------------------------------------------
module hdc_ctrl
  import hdc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        out_full,
  output logic        out_load,
  input  hdc_status_t status,
  output hdc_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CORDIC = 4'd1;
  localparam logic [3:0] S_FIN    = 4'd2;
  localparam logic [3:0] S_FORM   = 4'd3;
  localparam logic [3:0] S_OUT    = 4'd4;
  localparam logic [3:0] S_WST    = 4'd5;
  localparam logic [3:0] S_WDIV   = 4'd6;
  localparam logic [3:0] S_WAPP   = 4'd7;
  localparam logic [3:0] S_GST    = 4'd8;
  localparam logic [3:0] S_GDIV   = 4'd9;
  localparam logic [3:0] S_GAPP   = 4'd10;

  localparam int DIV_STEPS = 48;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_next        = cnt + 6'd1;
        if (cnt == 6'(CORDIC_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish_compass = 1'b1;
        state_next         = S_FORM;
      end
      S_FORM: begin
        cmd.form_headings = 1'b1;
        state_next        = S_OUT;
      end
      S_OUT: begin
        if (!out_full) begin
          out_load   = 1'b1;
          state_next = S_WST;
        end
      end
      S_WST: begin
        cmd.div_start_wheel = 1'b1;
        cnt_next            = '0;
        state_next          = S_WDIV;
      end
      S_WDIV: begin
        if (!status.div_needed) begin
          state_next = S_WAPP;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) state_next = S_WAPP;
        end
      end
      S_WAPP: begin
        cmd.apply_wheel = 1'b1;
        state_next      = S_GST;
      end
      S_GST: begin
        cmd.div_start_gyro = 1'b1;
        cnt_next           = '0;
        state_next         = S_GDIV;
      end
      S_GDIV: begin
        if (!status.div_needed) begin
          state_next = S_GAPP;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) state_next = S_GAPP;
        end
      end
      S_GAPP: begin
        cmd.apply_gyro = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/hdc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_datapath
// cordic, wheel product, wrap, nudge divider and drift state
// ----------------------------------------------------------------------------
module hdc_datapath
  import hdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  hdc_cmd_t           cmd,
  output hdc_status_t        status,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [31:0] left_position,
  input  logic signed [31:0] right_position,
  input  logic signed [31:0] gyro_angle,
  input  logic [31:0]        timestamp_us,
  input  logic [15:0]        noise_fraction,
  input  logic [14:0]        max_drift_step,
  input  logic [26:0]        update_interval,
  input  logic [31:0]        encoder_gain,
  output logic signed [15:0] compass_res,
  output logic signed [15:0] wheel_res,
  output logic signed [15:0] gyro_res
);

  localparam int HALF = 180 * (1 << ANGLE_FRAC_BITS);
  localparam int FULL = 2 * HALF;
  localparam int SHR  = TAB_FRAC - ANGLE_FRAC_BITS;
  // full turn is 45 << LO_W
  localparam int LO_W = ANGLE_FRAC_BITS + 3;
  localparam logic [24:0] RECIP45 = 25'd23860930;

  // wrap for values within a few turns
  function automatic logic signed [19:0] wrap20(input logic signed [19:0] v);
    logic signed [19:0] r;
    begin
      r = v;
      if (r > 20'(HALF)) r = r - 20'(FULL);
      if (r > 20'(HALF)) r = r - 20'(FULL);
      if (r <= -20'(HALF)) r = r + 20'(FULL);
      if (r <= -20'(HALF)) r = r + 20'(FULL);
      return r;
    end
  endfunction

  // remainder by a full turn via reciprocal multiply on the upper bits
  function automatic logic [15:0] mod_full(input logic [31:0] v);
    logic [23:0] hi;
    logic [48:0] p;
    logic [18:0] q;
    logic [5:0]  r;
    begin
      hi = 24'(v >> LO_W);
      p  = 49'(hi) * 49'(RECIP45);
      q  = p[48:30];
      r  = 6'(hi - 24'(q) * 24'd45);
      return 16'({r, v[LO_W-1:0]});
    end
  endfunction

  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic [STEP_W-1:0]  ci;
  logic               czero;
  logic signed [32:0] diff;
  logic signed [31:0] gyro_in;
  logic [31:0]        ts;
  logic signed [15:0] start_heading;
  logic               start_captured;
  logic signed [15:0] wheel_offset, gyro_offset;
  logic [31:0]        wheel_last_time, gyro_last_time;

  // serial divider and nudge state
  logic               due, far, errpos, bypass;
  logic [14:0]        step_full;
  logic [47:0]        dividend;
  logic [32:0]        divisor;
  logic [33:0]        rem;
  logic [14:0]        quo;

  logic signed [33:0] zr;
  logic signed [15:0] compass_calc;
  logic [31:0]        dmag;
  logic [63:0]        prod;
  logic [31:0]        wheel_q;
  logic signed [32:0] gneg;
  logic [31:0]        gmag;
  logic [31:0]        gyro_mag;
  logic               gyro_neg;
  logic signed [19:0] wheel_mod, gyro_mod;

  logic signed [15:0] sel_head;
  logic [31:0]        sel_last;
  logic signed [17:0] err;
  logic [16:0]        abs_err;
  logic [15:0]        abs_c;
  logic [31:0]        bound;
  logic [32:0]        bound_ext;
  logic signed [19:0] step_signed;
  logic [14:0]        step_mag;
  logic [33:0]        trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_captured  <= 1'b0;
      start_heading   <= '0;
      wheel_offset    <= '0;
      gyro_offset     <= '0;
      wheel_last_time <= '0;
      gyro_last_time  <= '0;
    end else begin
      if (cmd.finish_compass && !start_captured) begin
        start_captured <= 1'b1;
        start_heading  <= compass_calc;
      end
      if (cmd.apply_wheel && due) begin
        wheel_last_time <= ts;
        wheel_offset    <= 16'(wrap20(20'(wheel_offset) + step_signed));
      end
      if (cmd.apply_gyro && due) begin
        gyro_last_time <= ts;
        gyro_offset    <= 16'(wrap20(20'(gyro_offset) + step_signed));
      end
    end
  end

  // compass finish
  always_comb begin
    zr = (cz + (34'sd1 <<< (SHR - 1))) >>> SHR;
    compass_calc = czero ? 16'sd0 : 16'(wrap20(20'(zr)));
  end

  // wheel product and gyro magnitude
  always_comb begin
    dmag = diff[32] ? 32'(-diff) : 32'(diff);
    prod = 64'(dmag) * 64'(encoder_gain) + (64'd1 << 31);
    gneg = -33'(gyro_in);
    gmag = gneg[32] ? 32'(-gneg) : 32'(gneg);
  end

  // nudge setup for the selected path
  always_comb begin
    sel_head  = cmd.div_start_gyro ? gyro_res : wheel_res;
    sel_last  = cmd.div_start_gyro ? gyro_last_time : wheel_last_time;
    err       = 18'(compass_res) - 18'(sel_head);
    abs_err   = err[17] ? 17'(-err) : 17'(err);
    abs_c     = compass_res[15] ? 16'(-compass_res) : 16'(compass_res);
    bound     = 32'(noise_fraction) * 32'(abs_c);
    bound_ext = {abs_err, 16'd0};
    step_mag  = bypass ? step_full : quo;
    step_signed = (errpos ^ far) ? 20'(step_mag) : -20'(step_mag);
  end

  assign status.div_needed = !bypass;

  always_comb trial = {rem[32:0], dividend[47]} - 34'(divisor);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx      <= 36'(mag_x[15] ? -17'(mag_x) : 17'(mag_x)) <<< 16;
      cy      <= 36'(mag_x[15] ? -17'(mag_y) : 17'(mag_y)) <<< 16;
      cz      <= !mag_x[15] ? 34'sd0 :
                 (mag_y[15] ? -(34'sd180 <<< TAB_FRAC) : (34'sd180 <<< TAB_FRAC));
      czero   <= (mag_x == 16'sd0) && (mag_y == 16'sd0);
      ci      <= '0;
      diff    <= 33'(right_position) - 33'(left_position);
      gyro_in <= gyro_angle;
      ts      <= timestamp_us;
    end
    if (cmd.cordic_step) begin
      if (cy > 0) begin
        cx <= cx + (cy >>> ci);
        cy <= cy - (cx >>> ci);
        cz <= cz + 34'(atan_entry(ci));
      end else begin
        cx <= cx - (cy >>> ci);
        cy <= cy + (cx >>> ci);
        cz <= cz - 34'(atan_entry(ci));
      end
      ci       <= ci + 1'b1;
      wheel_q  <= prod[63:32];
      gyro_mag <= gmag;
      gyro_neg <= gneg[32];
    end
    if (cmd.finish_compass) begin
      compass_res <= compass_calc;
      wheel_mod   <= diff[32] ? -20'(mod_full(wheel_q)) : 20'(mod_full(wheel_q));
      gyro_mod    <= gyro_neg ? -20'(mod_full(gyro_mag)) : 20'(mod_full(gyro_mag));
    end
    if (cmd.form_headings) begin
      wheel_res <= 16'(wrap20(wheel_mod + 20'(start_heading) + 20'(wheel_offset)));
      gyro_res  <= 16'(wrap20(gyro_mod + 20'(gyro_offset) + 20'(start_heading)));
    end
    if (cmd.div_start_wheel || cmd.div_start_gyro) begin
      due       <= (ts - sel_last) > 32'(update_interval);
      far       <= abs_err > 17'(HALF);
      errpos    <= !err[17] && (err != 18'sd0);
      divisor   <= 33'(bound);
      dividend  <= 48'(max_drift_step) * 48'(abs_err) << 16;
      rem       <= '0;
      quo       <= '0;
      if (33'(bound_ext) > 33'(bound)) begin
        bypass    <= 1'b1;
        step_full <= max_drift_step;
      end else if (bound == 32'd0) begin
        bypass    <= 1'b1;
        step_full <= '0;
      end else begin
        bypass    <= 1'b0;
        step_full <= '0;
      end
    end
    if (cmd.div_step) begin
      dividend <= {dividend[46:0], 1'b0};
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[13:0], 1'b1};
      end else begin
        rem <= {rem[32:0], dividend[47]};
        quo <= {quo[13:0], 1'b0};
      end
    end
  end

endmodule

[src/heading_drift_corrector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_drift_corrector
// compass, wheel and gyro headings with per-path drift correction
// ----------------------------------------------------------------------------
// a request runs the CORDIC steps, compass finish and heading forming, then loads
// the result register; a new request is taken only after both drift updates,
//   which may each run the 48-step serial divider
// rst is synchronous: registers to defaults, offsets, timers and start cleared
module heading_drift_corrector
  import hdc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [31:0] left_position,
  input  logic signed [31:0] right_position,
  input  logic signed [31:0] gyro_angle,
  input  logic [31:0]        timestamp_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] compass_heading,
  output logic signed [15:0] wheel_heading,
  output logic signed [15:0] gyro_heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [15:0] noise_fraction;
  logic [14:0] max_drift_step;
  logic [26:0] update_interval;
  logic [31:0] encoder_gain;

  assign cfg_ready = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_fraction  <= 16'd1311;
      max_drift_step  <= 15'd51;
      update_interval <= 27'd1000000;
      encoder_gain    <= 32'd20026500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NOISE:    noise_fraction  <= cfg_data[15:0];
        REG_MAXSTEP:  max_drift_step  <= cfg_data[14:0];
        REG_INTERVAL: update_interval <= cfg_data[26:0];
        REG_GAIN:     encoder_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  hdc_cmd_t           cmd;
  hdc_status_t        status;
  logic               out_load;
  logic signed [15:0] compass_res, wheel_res, gyro_res;

  hdc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_full (out_valid && out_stall),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  hdc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mag_x           (mag_x),
    .mag_y           (mag_y),
    .left_position   (left_position),
    .right_position  (right_position),
    .gyro_angle      (gyro_angle),
    .timestamp_us    (timestamp_us),
    .noise_fraction  (noise_fraction),
    .max_drift_step  (max_drift_step),
    .update_interval (update_interval),
    .encoder_gain    (encoder_gain),
    .compass_res     (compass_res),
    .wheel_res       (wheel_res),
    .gyro_res        (gyro_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      compass_heading <= compass_res;
      wheel_heading   <= wheel_res;
      gyro_heading    <= gyro_res;
    end
  end

endmodule

[src/hdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_checker
// port-level checks of the heading drift corrector
// ----------------------------------------------------------------------------
module hdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] compass_heading,
  input logic signed [15:0] wheel_heading,
  input logic signed [15:0] gyro_heading
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("no busy after request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(compass_heading))
    else $error("result dropped");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> compass_heading <= 16'sd23040 && compass_heading > -16'sd23040 &&
      wheel_heading <= 16'sd23040 && wheel_heading > -16'sd23040 &&
      gyro_heading <= 16'sd23040 && gyro_heading > -16'sd23040)
    else $error("heading out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset state");

endmodule

bind heading_drift_corrector hdc_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .compass_heading (compass_heading),
  .wheel_heading   (wheel_heading),
  .gyro_heading    (gyro_heading)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for heading_drift_corrector: a bit-true predictor of
// the compass, wheel and gyro headings and drift offsets is run for every
// accepted request; results are compared in order under random idling
// ----------------------------------------------------------------------------
module tb_top
  import hdc_pkg::*;
();

  localparam int HALF = 180 * 128;
  localparam int FULL = 2 * HALF;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  logic in_valid = 1'b0, in_stall;
  logic signed [15:0] mag_x = '0, mag_y = '0;
  logic signed [31:0] left_position = '0, right_position = '0, gyro_angle = '0;
  logic [31:0] timestamp_us = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] compass_heading, wheel_heading, gyro_heading;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = REG_NOISE;
  logic [31:0] cfg_data = '0;

  heading_drift_corrector dut (.*);

  typedef struct packed {
    logic signed [15:0] compass;
    logic signed [15:0] wheel;
    logic signed [15:0] gyro;
  } headings_t;

  headings_t expected_headings[$];

  longint unsigned noise_frac, max_step, interval, gain;
  longint gyro_off, wheel_off, start_hdg;
  longint unsigned gyro_last, wheel_last;
  bit start_seen;
  int mismatches = 0, checked = 0, sent = 0, idle_cycles = 0;
  bit stall_mode = 1'b1;

  function automatic longint wrap_deg(longint v);
    longint r;
    r = v % FULL;
    if (r < 0) r += FULL;
    if (r > HALF) r -= FULL;
    return r;
  endfunction

  function automatic longint sra(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_coef(int i);
    longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342, 58671,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  function automatic longint compass_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (longint'(180) << 24) : -(longint'(180) << 24);
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 16; i++) begin
      dx = sra(x, i);
      dy = sra(y, i);
      if (y > 0) begin
        x += dy; y -= dx; z += atan_coef(i);
      end else begin
        x -= dy; y += dx; z -= atan_coef(i);
      end
    end
    return wrap_deg(sra(z + (longint'(1) << 16), 17));
  endfunction

  function automatic longint wheel_angle(longint l, longint r);
    longint d;
    longint unsigned m, q;
    d = r - l;
    m = (d < 0) ? longint'(-d) : d;
    q = (m * gain + (64'd1 << 31)) >> 32;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint drift_step(longint hdg, longint cmp);
    longint err;
    longint unsigned ae, am, bound, stp;
    bit far;
    err = cmp - hdg;
    ae = (err < 0) ? -err : err;
    am = (cmp < 0) ? -cmp : cmp;
    bound = noise_frac * am;
    far = ae > HALF;
    if ((ae << 16) > bound) stp = max_step;
    else if (bound == 0) stp = 0;
    else stp = ((max_step * ae) << 16) / bound;
    if (err > 0) return far ? -longint'(stp) : longint'(stp);
    return far ? longint'(stp) : -longint'(stp);
  endfunction

  task automatic predict_headings(logic signed [15:0] mx, my, logic signed [31:0] lp,
                                  rp, ga, logic [31:0] ts);
    longint c, w, g;
    headings_t h;
    c = compass_angle(mx, my);
    if (!start_seen) begin
      start_hdg = c;
      start_seen = 1'b1;
    end
    w = wrap_deg(wheel_angle(lp, rp) + start_hdg + wheel_off);
    g = wrap_deg(-longint'(ga) + gyro_off + start_hdg);
    h.compass = c[15:0];
    h.wheel = w[15:0];
    h.gyro = g[15:0];
    expected_headings.push_back(h);
    if (32'(ts - gyro_last[31:0]) > interval) begin
      gyro_last = ts;
      gyro_off = wrap_deg(gyro_off + drift_step(g, c));
    end
    if (32'(ts - wheel_last[31:0]) > interval) begin
      wheel_last = ts;
      wheel_off = wrap_deg(wheel_off + drift_step(w, c));
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(logic signed [15:0] mx, my, logic signed [31:0] lp, rp,
                              ga, logic [31:0] ts);
    int g;
    g = stall_mode ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    mag_x <= mx; mag_y <= my;
    left_position <= lp; right_position <= rp;
    gyro_angle <= ga; timestamp_us <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_headings(mx, my, lp, rp, ga, ts);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_headings.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NOISE: noise_frac = val[15:0];
      REG_MAXSTEP: max_step = val[14:0];
      REG_INTERVAL: interval = val[26:0];
      default: gain = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receive side: random stall, check against oldest expectation
  always @(posedge clk) begin
    headings_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_headings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                       compass_heading, wheel_heading, gyro_heading);
      end else begin
        e = expected_headings.pop_front();
        checked++;
        if (e.compass !== compass_heading || e.wheel !== wheel_heading ||
            e.gyro !== gyro_heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp c=%0d w=%0d g=%0d got c=%0d w=%0d g=%0d",
                     e.compass, e.wheel, e.gyro, compass_heading, wheel_heading,
                     gyro_heading);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_mode) out_stall <= ($urandom_range(0, 99) < 20) ? 1'b1 : 1'b0;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic rand_request(logic [31:0] ts);
    logic signed [31:0] l;
    l = $urandom;
    send_request(16'($urandom), 16'($urandom), l,
                 ($urandom_range(0, 3) == 0) ? $urandom : l + $urandom_range(0, 4000) - 2000,
                 $urandom, ts);
  endtask

  task automatic test_defaults();
    send_request(0, 0, 0, 0, 0, 0);
    send_request(16'sh7fff, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff);
    send_request(16'sh8000, 16'sh8000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 5);
    send_request(16'sh8000, 0, 100, -100, 23040, 2000000);
    send_request(-5, 16'sh7fff, 0, 0, -23040, 3000001);
    send_request(0, -1, 0, 1000, 46080, 4000002);
    send_request(3, 3, 0, 0, 0, 4000003);
    wait_drained();
  endtask

  task automatic test_zero_bound_interval();
    write_reg(REG_NOISE, 0);
    write_reg(REG_INTERVAL, 0);
    write_reg(REG_MAXSTEP, 23040);
    write_reg(REG_GAIN, 32'hffffffff);
    for (int i = 0; i < 8; i++) send_request(0, 0, 0, i * 7, -i * 1000, 10 + i);
    send_request(100, 0, 0, 0, 0, 10 + 8);
    send_request(-100, 0, 0, 0, 0, 10 + 8);
    wait_drained();
    write_reg(REG_NOISE, 16'hffff);
    write_reg(REG_MAXSTEP, 15'h7fff);
    write_reg(REG_INTERVAL, 27'h7ffffff);
    write_reg(REG_GAIN, 0);
    send_request(100, 50, 10, 20, 30, 32'h08000000);
    send_request(-100, 50, 10, 20, 30, 32'h10000001);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [31:0] ts;
    ts = $urandom;
    for (int i = 0; i < n; i++) begin
      ts += (interval > 1000) ? $urandom_range(0, interval * 2)
                              : $urandom_range(0, 4);
      if ($urandom_range(0, 30) == 0) ts = $urandom;
      rand_request(ts);
    end
    wait_drained();
  endtask

  task automatic test_settings();
    write_reg(REG_NOISE, 1311); write_reg(REG_MAXSTEP, 51);
    write_reg(REG_INTERVAL, 1000); write_reg(REG_GAIN, 20026500);
    test_random(200);
    stall_mode = 1'b0;
    test_random(100);
    stall_mode = 1'b1;
    write_reg(REG_NOISE, $urandom); write_reg(REG_MAXSTEP, $urandom_range(0, 23040));
    write_reg(REG_INTERVAL, $urandom_range(0, 3)); write_reg(REG_GAIN, $urandom);
    test_random(250);
    write_reg(REG_NOISE, 65535); write_reg(REG_MAXSTEP, 32767);
    write_reg(REG_INTERVAL, 1); write_reg(REG_GAIN, 32'hffffffff);
    test_random(150);
    write_reg(REG_NOISE, 0); write_reg(REG_MAXSTEP, 0);
    write_reg(REG_INTERVAL, 100000000); write_reg(REG_GAIN, 0);
    test_random(130);
  endtask

  initial begin
    noise_frac = 1311; max_step = 51; interval = 1000000; gain = 20026500;
    gyro_off = 0; wheel_off = 0; gyro_last = 0; wheel_last = 0;
    start_hdg = 0; start_seen = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_zero_bound_interval();
    test_settings();
    $display("sent %0d requests, checked %0d results over default, zero-bound,",
             sent, checked);
    $display("extreme and random register settings; mismatches %0d", mismatches);
    if (mismatches == 0 && expected_headings.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule

[filelist.f]
src/hdc_pkg.sv
src/hdc_ctrl.sv
src/hdc_datapath.sv
src/heading_drift_corrector.sv
src/hdc_checker.sv
bench/tb_top.sv
